FILE: rtl/u8md_pkg.sv
// Shared types and constants for the UTF-8 validator / GBK-misread detector.
// No dependencies.
`default_nettype none

package u8md_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic utf8_valid;
        logic likely_gbk_misread;
    } out_word_t;

    typedef enum logic [1:0] {
        PFX_0    = 2'd0,
        PFX_1    = 2'd1,
        PFX_2    = 2'd2,
        PFX_DONE = 2'd3
    } prefix_t;

    typedef enum logic [2:0] {
        LC_NONE  = 3'd0,
        LC_TWO   = 3'd1,
        LC_E0    = 3'd2,
        LC_ED    = 3'd3,
        LC_THREE = 3'd4,
        LC_F0    = 3'd5,
        LC_F4    = 3'd6,
        LC_FOUR  = 3'd7
    } lead_t;

    typedef struct packed {
        prefix_t     prefix_count;
        logic        bom_seen;
        logic        malformed;
        logic [1:0]  bytes_pending;
        lead_t       lead_class;
        logic [15:0] code_accum;
        logic        saw_cjk;
        logic        saw_legacy;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        prefix_count:  PFX_0,
        bom_seen:      1'b0,
        malformed:     1'b0,
        bytes_pending: 2'd0,
        lead_class:    LC_NONE,
        code_accum:    16'h0000,
        saw_cjk:       1'b0,
        saw_legacy:    1'b0
    };

    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD_E0  = 8'hE0;
    localparam logic [7:0] LEAD_ED  = 8'hED;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] LEAD_F0  = 8'hF0;
    localparam logic [7:0] LEAD_F4  = 8'hF4;
    localparam logic [7:0] ASCII_HI = 8'h7F;

    localparam logic [7:0] CONT_E0_MIN = 8'hA0;
    localparam logic [7:0] CONT_ED_MAX = 8'h9F;
    localparam logic [7:0] CONT_F0_MIN = 8'h90;
    localparam logic [7:0] CONT_F4_MAX = 8'h8F;

endpackage

`default_nettype wire

FILE: rtl/u8md_step.sv
// Per-byte next-state and result logic for the UTF-8 validator.
// Depends on u8md_pkg.
`default_nettype none

module u8md_step (
    input  var u8md_pkg::state_t    cur,
    input  var u8md_pkg::in_word_t  in_word,
    output var u8md_pkg::state_t    nxt,
    output var u8md_pkg::out_word_t res
);

    function automatic logic is_cjk(input logic [15:0] pt);
        is_cjk = (pt inside {[16'h3400:16'h4DBF]}) || (pt inside {[16'h4E00:16'h9FFF]})
              || (pt inside {[16'h3000:16'h303F]}) || (pt inside {[16'hFF00:16'hFFEF]});
    endfunction

    function automatic logic is_legacy(input logic [15:0] pt);
        is_legacy = pt inside {[16'h0100:16'h052F]};
    endfunction

    logic [7:0]        b;
    logic              first_cont;
    logic              cont_ok;
    logic              lead_path;
    logic [15:0]       cp;
    logic              mal_end;
    logic              valid;
    u8md_pkg::state_t  s;

    assign b  = in_word.text_byte;
    assign cp = {cur.code_accum[9:0], b[5:0]};

    always_comb begin
        if (cur.lead_class inside {u8md_pkg::LC_E0, u8md_pkg::LC_ED, u8md_pkg::LC_THREE}) begin
            first_cont = (cur.bytes_pending == 2'd2);
        end else if (cur.lead_class inside {u8md_pkg::LC_F0, u8md_pkg::LC_F4,
                                             u8md_pkg::LC_FOUR}) begin
            first_cont = (cur.bytes_pending == 2'd3);
        end else begin
            first_cont = 1'b0;
        end

        cont_ok = (b[7:6] == 2'b10);
        if (first_cont) begin
            case (cur.lead_class)
                u8md_pkg::LC_E0: cont_ok = cont_ok && (b >= u8md_pkg::CONT_E0_MIN);
                u8md_pkg::LC_ED: cont_ok = cont_ok && (b <= u8md_pkg::CONT_ED_MAX);
                u8md_pkg::LC_F0: cont_ok = cont_ok && (b >= u8md_pkg::CONT_F0_MIN);
                u8md_pkg::LC_F4: cont_ok = cont_ok && (b <= u8md_pkg::CONT_F4_MAX);
                default: ;
            endcase
        end
    end

    always_comb begin
        s = cur;

        // BOM prefix tracking
        case (cur.prefix_count)
            u8md_pkg::PFX_0:
                s.prefix_count = (b == u8md_pkg::BOM_B0) ? u8md_pkg::PFX_1 : u8md_pkg::PFX_DONE;
            u8md_pkg::PFX_1:
                s.prefix_count = (b == u8md_pkg::BOM_B1) ? u8md_pkg::PFX_2 : u8md_pkg::PFX_DONE;
            u8md_pkg::PFX_2: begin
                if (b == u8md_pkg::BOM_B2) begin
                    s.bom_seen = 1'b1;
                end
                s.prefix_count = u8md_pkg::PFX_DONE;
            end
            default: ;
        endcase

        // continuation of an open sequence
        lead_path = 1'b1;
        if (cur.bytes_pending != 2'd0) begin
            if (cont_ok) begin
                lead_path       = 1'b0;
                s.code_accum    = cp;
                s.bytes_pending = cur.bytes_pending - 2'd1;
                if (cur.bytes_pending == 2'd1) begin
                    if (cur.lead_class inside {u8md_pkg::LC_TWO, u8md_pkg::LC_E0,
                                               u8md_pkg::LC_ED, u8md_pkg::LC_THREE}) begin
                        s.saw_cjk    = cur.saw_cjk | is_cjk(cp);
                        s.saw_legacy = cur.saw_legacy | is_legacy(cp);
                    end
                    s.lead_class = u8md_pkg::LC_NONE;
                end
            end else begin
                s.malformed     = 1'b1;
                s.bytes_pending = 2'd0;
                s.lead_class    = u8md_pkg::LC_NONE;
            end
        end

        // lead byte decode; ASCII never hits any of the lead ranges
        if (lead_path) begin
            if (b <= u8md_pkg::ASCII_HI) begin
                s.bytes_pending = s.bytes_pending;
            end else if (b inside {[u8md_pkg::LEAD2_LO:u8md_pkg::LEAD2_HI]}) begin
                s.bytes_pending = 2'd1;
                s.lead_class    = u8md_pkg::LC_TWO;
                s.code_accum    = {11'd0, b[4:0]};
            end else if (b inside {[u8md_pkg::LEAD3_LO:u8md_pkg::LEAD3_HI]}) begin
                s.bytes_pending = 2'd2;
                s.lead_class    = (b == u8md_pkg::LEAD_E0) ? u8md_pkg::LC_E0 :
                                  (b == u8md_pkg::LEAD_ED) ? u8md_pkg::LC_ED :
                                                             u8md_pkg::LC_THREE;
                s.code_accum    = {12'd0, b[3:0]};
            end else if (b inside {[u8md_pkg::LEAD4_LO:u8md_pkg::LEAD4_HI]}) begin
                s.bytes_pending = 2'd3;
                s.lead_class    = (b == u8md_pkg::LEAD_F0) ? u8md_pkg::LC_F0 :
                                  (b == u8md_pkg::LEAD_F4) ? u8md_pkg::LC_F4 :
                                                             u8md_pkg::LC_FOUR;
                s.code_accum    = {13'd0, b[2:0]};
            end else begin
                s.malformed = 1'b1;
            end
        end

        // end of string
        mal_end = s.malformed || (s.bytes_pending != 2'd0);
        valid   = s.bom_seen || !mal_end;
        res.utf8_valid         = valid;
        res.likely_gbk_misread = valid && !s.saw_cjk && s.saw_legacy;

        nxt = in_word.final_byte ? u8md_pkg::STATE_CLEAR : s;
    end

endmodule

`default_nettype wire

FILE: rtl/utf8_validate_mojibake_detect.sv
// The verdict is registered: m_valid rises in the cycle after the final byte of a string is accepted.
// Throughput: one byte per cycle while s_ready is high; the byte-state update is combinational.
// s_ready stays high while the result register is empty or being drained.
// Reset (aresetn low, synchronous) clears string state and the result valid.
// Top level of the UTF-8 validator / GBK-misread detector; uses u8md_pkg, u8md_step.
`default_nettype none

module utf8_validate_mojibake_detect (
    input  var logic                aclk,
    input  var logic                aresetn,
    input  var logic                s_valid,
    output var logic                s_ready,
    input  var u8md_pkg::in_word_t  s_data,
    output var logic                m_valid,
    input  var logic                m_ready,
    output var u8md_pkg::out_word_t m_data
);

    u8md_pkg::state_t    state_reg;
    u8md_pkg::state_t    state_next;
    u8md_pkg::out_word_t res_next;
    u8md_pkg::out_word_t m_data_reg;
    logic                m_valid_reg;
    logic                accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    u8md_step u_step (
        .cur     (state_reg),
        .in_word (s_data),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= u8md_pkg::STATE_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept && s_data.final_byte) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_data.final_byte) begin
            m_data_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/u8md_checker.sv
// Port-level checks for utf8_validate_mojibake_detect, bound to the top level.
// Depends on u8md_pkg.
`default_nettype none

module u8md_checker (
    input var logic                aclk,
    input var logic                aresetn,
    input var logic                s_valid,
    input var logic                s_ready,
    input var u8md_pkg::in_word_t  s_data,
    input var logic                m_valid,
    input var logic                m_ready,
    input var u8md_pkg::out_word_t m_data
);

    a_gbk_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.utf8_valid || !m_data.likely_gbk_misread))
        else $error("gbk verdict on invalid string");

    a_result_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.final_byte))
        else $error("result without final word");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed while stalled");

endmodule

bind utf8_validate_mojibake_detect u8md_checker u_chk (.*);

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for utf8_validate_mojibake_detect: drives byte strings, predicts each
// string's validity and GBK-misread verdict, and compares every verdict word.
// Depends on rtl/u8md_pkg.sv and rtl/utf8_validate_mojibake_detect.sv.

module tb_top;

    localparam int CLK_PERIOD = 12;
    localparam int LIMIT_CYCLES = 300000;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    u8md_pkg::in_word_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    u8md_pkg::out_word_t m_data;

    utf8_validate_mojibake_detect u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predictor state for the string in progress
    u8md_pkg::prefix_t pfx;
    logic              bom;
    logic              bad;
    logic [1:0]        pend;
    u8md_pkg::lead_t   lc;
    logic [15:0]       acc;
    logic              cjk;
    logic              legacy;

    u8md_pkg::out_word_t verdict_q[$];
    logic [7:0]          text_q[$];

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_hold_len = 0;

    int bytes_sent = 0;
    int strings_sent = 0;
    int verdicts_checked = 0;
    int valid_seen = 0;
    int misread_seen = 0;
    int fail_count = 0;

    int unsigned boundary_cp [0:26] = '{
        'h0000, 'h007F, 'h0080, 'h00FF, 'h0100, 'h052F, 'h0530, 'h07FF, 'h0800,
        'h2FFF, 'h3000, 'h303F, 'h3040, 'h33FF, 'h3400, 'h4DBF, 'h4DC0, 'h4E00,
        'h9FFF, 'hA000, 'hD7FF, 'hE000, 'hFEFF, 'hFF00, 'hFFEF, 'hFFF0, 'h10FFFF
    };

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("tb_top: timeout with %0d verdicts outstanding", verdict_q.size());
        $display("tb_top: FAIL");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic void clear_text_state();
        pfx = u8md_pkg::PFX_0;
        bom = 1'b0;
        bad = 1'b0;
        pend = 2'd0;
        lc = u8md_pkg::LC_NONE;
        acc = 16'h0000;
        cjk = 1'b0;
        legacy = 1'b0;
    endfunction

    function automatic void note_cp(logic [15:0] cp);
        if ((cp >= 16'h3400 && cp <= 16'h4DBF) || (cp >= 16'h4E00 && cp <= 16'h9FFF) ||
            (cp >= 16'h3000 && cp <= 16'h303F) || (cp >= 16'hFF00 && cp <= 16'hFFEF))
            cjk = 1'b1;
        if (cp >= 16'h0100 && cp <= 16'h052F)
            legacy = 1'b1;
    endfunction

    function automatic void open_lead(logic [7:0] b);
        if (b <= u8md_pkg::ASCII_HI) begin
            note_cp({8'h00, b});
        end else if (b >= u8md_pkg::LEAD2_LO && b <= u8md_pkg::LEAD2_HI) begin
            pend = 2'd1;
            lc = u8md_pkg::LC_TWO;
            acc = {11'b0, b[4:0]};
        end else if (b >= u8md_pkg::LEAD3_LO && b <= u8md_pkg::LEAD3_HI) begin
            pend = 2'd2;
            if (b == u8md_pkg::LEAD_E0)
                lc = u8md_pkg::LC_E0;
            else if (b == u8md_pkg::LEAD_ED)
                lc = u8md_pkg::LC_ED;
            else
                lc = u8md_pkg::LC_THREE;
            acc = {12'b0, b[3:0]};
        end else if (b >= u8md_pkg::LEAD4_LO && b <= u8md_pkg::LEAD4_HI) begin
            pend = 2'd3;
            if (b == u8md_pkg::LEAD_F0)
                lc = u8md_pkg::LC_F0;
            else if (b == u8md_pkg::LEAD_F4)
                lc = u8md_pkg::LC_F4;
            else
                lc = u8md_pkg::LC_FOUR;
            acc = {13'b0, b[2:0]};
        end else begin
            bad = 1'b1;
        end
    endfunction

    function automatic logic cont_fits(logic [7:0] b);
        logic lead_pos;
        if (b[7:6] != 2'b10)
            return 1'b0;
        case (lc)
            u8md_pkg::LC_E0, u8md_pkg::LC_ED, u8md_pkg::LC_THREE:
                lead_pos = (pend == 2'd2);
            u8md_pkg::LC_F0, u8md_pkg::LC_F4, u8md_pkg::LC_FOUR:
                lead_pos = (pend == 2'd3);
            default:
                lead_pos = 1'b0;
        endcase
        if (!lead_pos)
            return 1'b1;
        case (lc)
            u8md_pkg::LC_E0: return b >= u8md_pkg::CONT_E0_MIN;
            u8md_pkg::LC_ED: return b <= u8md_pkg::CONT_ED_MAX;
            u8md_pkg::LC_F0: return b >= u8md_pkg::CONT_F0_MIN;
            u8md_pkg::LC_F4: return b <= u8md_pkg::CONT_F4_MAX;
            default:         return 1'b1;
        endcase
    endfunction

    function automatic void decode_byte(u8md_pkg::in_word_t w);
        logic [7:0]          b;
        u8md_pkg::out_word_t v;
        b = w.text_byte;
        case (pfx)
            u8md_pkg::PFX_0:
                pfx = (b == u8md_pkg::BOM_B0) ? u8md_pkg::PFX_1 : u8md_pkg::PFX_DONE;
            u8md_pkg::PFX_1:
                pfx = (b == u8md_pkg::BOM_B1) ? u8md_pkg::PFX_2 : u8md_pkg::PFX_DONE;
            u8md_pkg::PFX_2: begin
                if (b == u8md_pkg::BOM_B2)
                    bom = 1'b1;
                pfx = u8md_pkg::PFX_DONE;
            end
            default: ;
        endcase
        if (pend != 2'd0 && cont_fits(b)) begin
            acc = {acc[9:0], b[5:0]};
            pend = pend - 2'd1;
            if (pend == 2'd0) begin
                if (lc <= u8md_pkg::LC_THREE)
                    note_cp(acc);
                lc = u8md_pkg::LC_NONE;
            end
        end else begin
            if (pend != 2'd0) begin
                bad = 1'b1;
                pend = 2'd0;
                lc = u8md_pkg::LC_NONE;
            end
            open_lead(b);
        end
        if (w.final_byte) begin
            if (pend != 2'd0)
                bad = 1'b1;
            v.utf8_valid = bom || !bad;
            v.likely_gbk_misread = v.utf8_valid && !cjk && legacy;
            verdict_q = {verdict_q, v};
            clear_text_state();
        end
    endfunction

    initial clear_text_state();

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            decode_byte(s_data);
    end

    // ---------------- verdict checker ----------------

    always @(posedge aclk) begin
        u8md_pkg::out_word_t exp_v;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("tb_top: unexpected verdict word valid=%0b misread=%0b",
                             m_data.utf8_valid, m_data.likely_gbk_misread);
            end else begin
                exp_v = verdict_q.pop_front();
                if (m_data.utf8_valid !== exp_v.utf8_valid ||
                    m_data.likely_gbk_misread !== exp_v.likely_gbk_misread) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("tb_top: verdict %0d exp %0b/%0b got %0b/%0b (valid/misread)",
                                 verdicts_checked, exp_v.utf8_valid, exp_v.likely_gbk_misread,
                                 m_data.utf8_valid, m_data.likely_gbk_misread);
                end
            end
            verdicts_checked++;
            if (m_data.utf8_valid === 1'b1)
                valid_seen++;
            if (m_data.likely_gbk_misread === 1'b1)
                misread_seen++;
        end
    end

    // ---------------- receiver ----------------

    initial begin
        int stall_cycles;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (rx_hold_len > 0) begin
                m_ready <= 1'b0;
                stall_cycles = rx_hold_len;
                rx_hold_len = 0;
                while (stall_cycles > 0) begin
                    @(posedge aclk);
                    stall_cycles--;
                end
                m_ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- sender ----------------

    task automatic send_byte(logic [7:0] b, logic is_last);
        u8md_pkg::in_word_t w;
        w.text_byte = b;
        w.final_byte = is_last;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_data <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (is_last)
            strings_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic wait_verdicts_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0)
            @(posedge aclk);
    endtask

    function automatic void add_byte(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic void push_cp(logic [20:0] cp);
        if (cp < 21'h80) begin
            add_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end else begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] random_cp();
        logic [20:0] cp;
        case ($urandom_range(0, 9))
            0, 1: cp = 21'($urandom_range(0, 'h7F));
            2, 3: cp = 21'($urandom_range('h100, 'h52F));
            4: begin
                case ($urandom_range(0, 3))
                    0:       cp = 21'($urandom_range('h3000, 'h303F));
                    1:       cp = 21'($urandom_range('h3400, 'h4DBF));
                    2:       cp = 21'($urandom_range('h4E00, 'h9FFF));
                    default: cp = 21'($urandom_range('hFF00, 'hFFEF));
                endcase
            end
            5: cp = 21'($urandom_range('h80, 'h7FF));
            6: begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp - 21'h800;
            end
            7: cp = 21'($urandom_range('h10000, 'h10FFFF));
            default: cp = 21'(boundary_cp[$urandom_range(0, 26)]);
        endcase
        return cp;
    endfunction

    // overlong, surrogate, above-range or never-valid lead
    function automatic void insert_bad_seq();
        logic [7:0] seq[$];
        int pos;
        case ($urandom_range(0, 5))
            0: begin
                seq = {seq, 8'hC0 | 8'($urandom_range(0, 1))};
                seq = {seq, rand_cont()};
            end
            1: begin
                seq = {seq, 8'hE0};
                seq = {seq, 8'h80 | 8'($urandom_range(0, 31))};
                seq = {seq, rand_cont()};
            end
            2: begin
                seq = {seq, 8'hED};
                seq = {seq, 8'hA0 | 8'($urandom_range(0, 31))};
                seq = {seq, rand_cont()};
            end
            3: begin
                seq = {seq, 8'hF0};
                seq = {seq, 8'h80 | 8'($urandom_range(0, 15))};
                seq = {seq, rand_cont()};
                seq = {seq, rand_cont()};
            end
            4: begin
                seq = {seq, 8'hF4};
                seq = {seq, 8'($urandom_range('h90, 'hBF))};
                seq = {seq, rand_cont()};
                seq = {seq, rand_cont()};
            end
            default: seq = {seq, 8'($urandom_range('hF5, 'hFF))};
        endcase
        pos = $urandom_range(0, text_q.size());
        for (int j = 0; j < seq.size(); j++)
            text_q.insert(pos + j, seq[j]);
    endfunction

    function automatic void build_random_text();
        int n_cp;
        int pos;
        text_q.delete();
        case ($urandom_range(0, 9))
            0, 1: begin
                add_byte(u8md_pkg::BOM_B0);
                add_byte(u8md_pkg::BOM_B1);
                add_byte(u8md_pkg::BOM_B2);
            end
            2: add_byte(u8md_pkg::BOM_B0);
            3: begin
                add_byte(u8md_pkg::BOM_B0);
                add_byte(u8md_pkg::BOM_B1);
            end
            default: ;
        endcase
        n_cp = $urandom_range(1, 8);
        for (int k = 0; k < n_cp; k++)
            push_cp(random_cp());
        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 3))
                0: text_q[pos] = 8'($urandom_range(0, 255));
                1: text_q.insert(pos, 8'($urandom_range(0, 255)));
                2: void'(text_q.pop_back());
                default: insert_bad_seq();
            endcase
        end
        if (text_q.size() == 0)
            add_byte(8'($urandom_range(0, 255)));
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed_cases();
        text_q = {8'h00};                                // lowest byte
        send_text();
        text_q = {8'hFF};                                // highest byte, bad lead
        send_text();
        text_q = {8'hC1};                                // overlong two-byte lead
        send_text();
        text_q = {8'hC4, 8'h80};                         // legacy only: misread
        send_text();
        text_q = {8'hC4, 8'h80, 8'hE3, 8'h80, 8'h80};    // legacy plus CJK
        send_text();
        text_q = {8'hE0, 8'h9F};                         // overlong E0, 9F retaken as lead
        send_text();
        text_q = {8'hED, 8'hA0, 8'h80};                  // surrogate
        send_text();
        text_q = {8'hF4, 8'h8F, 8'hBF, 8'hBF};           // U+10FFFF, four-byte
        send_text();
        text_q = {8'hEF, 8'hBB, 8'hBF, 8'hFF, 8'hC4, 8'h80}; // junk after mark
        send_text();
        text_q = {8'hC4};                                // truncated at end
        send_text();
    endtask

    task automatic test_random_text(int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            build_random_text();
            send_text();
        end
    endtask

    task automatic test_random_noise();
        int stop_at;
        int len;
        stop_at = bytes_sent + 200;
        while (bytes_sent < stop_at) begin
            len = $urandom_range(1, 6);
            text_q.delete();
            repeat (len) add_byte(8'($urandom_range(0, 255)));
            send_text();
        end
    endtask

    task automatic test_result_backpressure();
        rx_hold_len = 250;
        repeat (40) begin
            text_q.delete();
            push_cp(random_cp());
            send_text();
        end
    endtask

    task automatic test_sender_drain_pause();
        repeat (6) begin
            build_random_text();
            send_text();
        end
        wait_verdicts_drained();
        repeat (4) begin
            build_random_text();
            send_text();
        end
    endtask

    task automatic test_streaming_no_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_text(250);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_text(1250);
        test_random_noise();
        test_result_backpressure();
        test_sender_drain_pause();
        test_streaming_no_idle();

        wait_verdicts_drained();
        repeat (8) @(posedge aclk);

        $display("tb_top: %0d bytes in %0d strings, %0d verdicts checked",
                 bytes_sent, strings_sent, verdicts_checked);
        $display("tb_top: %0d judged valid, %0d flagged as misread, %0d mismatches",
                 valid_seen, misread_seen, fail_count);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
